// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CHK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hsl assertion failed");

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hsl assertion failed");

`endif

// File: rtl/hsl_pkg.sv
// Types, constants and fixed-point helpers of the Heisenberg lattice update block.
`default_nettype none

package hsl_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int SIDE_BITS  = $clog2(MAX_SIDE);
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int CFG_W      = 7;
    localparam int MOD_W      = SIDE_BITS + CFG_W;
    localparam int FRAC_BITS  = 14;
    localparam int COMP_W     = 16;
    localparam int S_W        = FRAC_BITS + 1;
    localparam int BIT_W      = $clog2(FRAC_BITS + 1);
    localparam int RR_W       = 2 * FRAC_BITS + 1;
    localparam int MUL_W      = COMP_W + 2;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 48;
    localparam int E_W        = 29;
    localparam int M_W        = 28;
    localparam int MSUM_W     = COMP_W + ADDR_BITS + 1;
    localparam int NB_W       = COMP_W + 2;
    localparam int D_W        = COMP_W + 1;

    localparam logic signed [ACC_W-1:0] ONE_Q    = ACC_W'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ONE_SQ   = ACC_W'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HALF_Q   = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SPIN_LIM = ONE_Q;
    localparam logic signed [ACC_W-1:0] E_MAX    = (ACC_W'(1) <<< (E_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] E_MIN    = -E_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] M_MAX    = (ACC_W'(1) <<< (M_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] M_MIN    = -M_MAX - ACC_W'(1);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_PROPOSE = 2'd1,
        OP_ACCEPT  = 2'd2,
        OP_REJECT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_REDRAW = 2'd1,
        ST_NOPEND = 2'd2
    } t_status;

    typedef logic [COMP_W-1:0] t_comp;
    typedef t_comp [2:0] t_spin;   // [0] x, [1] y, [2] z

    typedef struct packed {
        t_op                      op;
        logic [SIDE_BITS-1:0]     site_x;
        logic [SIDE_BITS-1:0]     site_y;
        logic signed [COMP_W-1:0] val_a;
        logic signed [COMP_W-1:0] val_b;
        logic signed [COMP_W-1:0] val_c;
    } t_in_item;

    typedef struct packed {
        logic signed [E_W-1:0] energy;
        logic signed [M_W-1:0] mag_x;
        logic signed [M_W-1:0] mag_y;
        logic signed [M_W-1:0] mag_z;
        logic [1:0]            status;
    } t_out_item;

    typedef struct packed {
        logic mul;
        logic acc;
        logic clr;
    } t_mac_ctl;

    // Round to Q.FRAC_BITS, ties away from zero.
    function automatic logic signed [ACC_W-1:0] round_q(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] r;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r = (mag + ACC_W'(HALF_Q)) >> FRAC_BITS;
        round_q = v[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [COMP_W-1:0] clamp_spin(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = (v > SPIN_LIM) ? SPIN_LIM : ((v < -SPIN_LIM) ? -SPIN_LIM : v);
        clamp_spin = COMP_W'(c);
    endfunction

    function automatic logic signed [E_W-1:0] sat_e(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = (v > E_MAX) ? E_MAX : ((v < E_MIN) ? E_MIN : v);
        sat_e = E_W'(c);
    endfunction

    function automatic logic signed [M_W-1:0] sat_m(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = (v > M_MAX) ? M_MAX : ((v < M_MIN) ? M_MIN : v);
        sat_m = M_W'(c);
    endfunction

endpackage

`default_nettype wire

// File: rtl/hsl_spin_ram.sv
// Spin lattice memory: one write port, one registered read port.
`default_nettype none

module hsl_spin_ram import hsl_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire t_spin                i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output t_spin                     o_rdata
);

    t_spin r_mem [DEPTH];
    t_spin r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/hsl_mac.sv
// Shared multiplier with a registered product and a trailing accumulator.
`default_nettype none

module hsl_mac import hsl_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [MUL_W-1:0]  i_a,
    input  wire logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]      o_prod,
    output logic signed [ACC_W-1:0]       o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_acc_en;
    logic                     r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
            r_clr    <= 1'b0;
        end else begin
            r_acc_en <= i_ctl.acc;
            r_clr    <= i_ctl.clr;
        end
        if (i_ctl.mul) begin
            r_prod <= i_a * i_b;
        end
        // add the product in the cycle after it is formed
        if (r_acc_en) begin
            r_acc <= (r_clr ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

// File: rtl/heisenberg_lattice_spin_update.sv
// Top level of the Heisenberg lattice spin update block.
// Input channel: i_in_valid / o_in_stall carry one command word (load, propose,
// accept, reject) with site and three Q1.14 values. Output channel:
// o_out_valid / i_out_stall return one word per command: energy, x/y/z
// magnetization and a status code. Config channel: i_cfg_valid / o_cfg_ready
// writes the lattice side; ready is always high.
// One command at a time runs through a sequencer around one shared multiplier
// and the spin memory (one write port, one registered read port). A propose
// either asks for a redraw or makes a local update (15-bit root found one bit
// at a time, four neighbour reads, three products); the first propose after a
// load or reset instead sweeps the whole lattice in use (the sweep reads three
// words and forms three products per site).
// The input stalls from accept until the word is loaded into the output
// register; a command that completes while that word is still stalled waits.
// Reset: lattice side 64, totals and saved state zero, spin memory undefined
// until loaded, no clearing pass.
`default_nettype none

module heisenberg_lattice_spin_update import hsl_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_MOD    = 13'b0000000000010,
        S_DISP   = 13'b0000000000100,
        S_SQ     = 13'b0000000001000,
        S_ROOT   = 13'b0000000010000,
        S_NEW    = 13'b0000000100000,
        S_SW_RD  = 13'b0000001000000,
        S_SW_MUL = 13'b0000010000000,
        S_SW_FIN = 13'b0000100000000,
        S_LC_RD  = 13'b0001000000000,
        S_LC_MUL = 13'b0010000000000,
        S_LC_FIN = 13'b0100000000000,
        S_FIN    = 13'b1000000000000
    } t_state;

    t_state                   r_state;
    logic [3:0]               r_step;
    logic [1:0]               r_k;
    logic [BIT_W-1:0]         r_bit;
    t_op                      r_op;
    logic [SIDE_BITS-1:0]     r_x, r_y;
    logic signed [COMP_W-1:0] r_a, r_b, r_c;
    logic [CFG_W-1:0]         r_side, r_n;
    logic [RR_W-1:0]          r_rr, r_d;
    logic [S_W-1:0]           r_s;
    t_spin                    r_old, r_new, r_cs, r_ls, r_bs;
    logic signed [COMP_W-1:0] r_nx;
    logic [SIDE_BITS-1:0]     r_sx, r_sy;
    logic                     r_first;
    logic signed [MSUM_W-1:0] r_m [3];
    logic signed [NB_W-1:0]   r_nb [3];
    logic signed [E_W-1:0]    r_energy, r_sv_energy;
    logic signed [M_W-1:0]    r_mag [3];
    logic signed [M_W-1:0]    r_sv_mag [3];
    t_spin                    r_sv_spin;
    logic [ADDR_BITS-1:0]     r_sv_site;
    logic                     r_pending, r_measured;
    t_status                  r_status;
    t_out_item                r_out;
    logic                     r_ovalid;

    logic [SIDE_BITS-1:0]     w_last, w_xl, w_xr, w_yb, w_ya, w_sxl, w_syb;
    logic [MOD_W-1:0]         w_nsh;
    logic [S_W-1:0]           w_t;
    logic [ADDR_BITS-1:0]     w_raddr, w_waddr;
    logic                     w_we;
    t_spin                    w_wdata, w_rdata;
    t_mac_ctl                 w_ctl;
    logic signed [MUL_W-1:0]  w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [COMP_W-1:0] w_rnd, w_nz;
    logic signed [D_W-1:0]    w_d [3];
    logic [CFG_W-1:0]         w_side_use;

    hsl_spin_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hsl_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_prod  (w_prod),
        .o_acc   (w_acc)
    );

    always_comb begin
        if (r_side < CFG_W'(2)) begin
            w_side_use = CFG_W'(2);
        end else if (r_side > CFG_W'(MAX_SIDE)) begin
            w_side_use = CFG_W'(MAX_SIDE);
        end else begin
            w_side_use = r_side;
        end
    end

    // periodic neighbours
    always_comb begin
        w_last = SIDE_BITS'(r_n - CFG_W'(1));
        w_xl  = (r_x == '0) ? w_last : r_x - SIDE_BITS'(1);
        w_xr  = (r_x == w_last) ? '0 : r_x + SIDE_BITS'(1);
        w_yb  = (r_y == '0) ? w_last : r_y - SIDE_BITS'(1);
        w_ya  = (r_y == w_last) ? '0 : r_y + SIDE_BITS'(1);
        w_sxl = (r_sx == '0) ? w_last : r_sx - SIDE_BITS'(1);
        w_syb = (r_sy == '0) ? w_last : r_sy - SIDE_BITS'(1);
        w_nsh = MOD_W'(r_n) << r_step[2:0];
        w_t   = r_s | (S_W'(1) << r_bit);
        w_rnd = clamp_spin(round_q(ACC_W'(w_prod) <<< 1));
        w_nz  = clamp_spin(round_q(ONE_SQ - ($signed(ACC_W'(r_rr)) <<< 1)));
        for (int k = 0; k < 3; k++) begin
            w_d[k] = D_W'($signed(r_new[k])) - D_W'($signed(r_old[k]));
        end
    end

    always_comb begin
        w_raddr = {r_x, r_y};
        case (r_state)
            S_SW_RD: begin
                case (r_step[1:0])
                    2'd0:    w_raddr = {r_sx, r_sy};
                    2'd1:    w_raddr = {w_sxl, r_sy};
                    default: w_raddr = {r_sx, w_syb};
                endcase
            end
            S_LC_RD: begin
                case (r_step[1:0])
                    2'd0:    w_raddr = {w_xl, r_y};
                    2'd1:    w_raddr = {w_xr, r_y};
                    2'd2:    w_raddr = {r_x, w_yb};
                    default: w_raddr = {r_x, w_ya};
                endcase
            end
            default: w_raddr = {r_x, r_y};
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_x, r_y};
        w_wdata = {r_c, r_b, r_a};
        if (r_state == S_DISP && r_op == OP_LOAD) begin
            w_we = 1'b1;
        end else if (r_state == S_DISP && r_op == OP_REJECT && r_pending) begin
            w_we    = 1'b1;
            w_waddr = r_sv_site;
            w_wdata = r_sv_spin;
        end else if (r_state == S_NEW && r_step == 4'd2) begin
            w_we    = 1'b1;
            w_wdata = {w_nz, w_rnd, r_nx};
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        w_ctl = '0;
        w_ma  = '0;
        w_mb  = '0;
        case (r_state)
            S_SQ: begin
                if (r_step == 4'd0) begin
                    w_ctl = '{mul: 1'b1, acc: 1'b1, clr: 1'b1};
                    w_ma  = MUL_W'(r_a);
                    w_mb  = MUL_W'(r_a);
                end else if (r_step == 4'd1) begin
                    w_ctl = '{mul: 1'b1, acc: 1'b1, clr: 1'b0};
                    w_ma  = MUL_W'(r_b);
                    w_mb  = MUL_W'(r_b);
                end
            end
            S_ROOT: begin
                w_ctl.mul = !r_k[0];
                w_ma      = MUL_W'($signed({1'b0, w_t}));
                w_mb      = MUL_W'($signed({1'b0, w_t}));
            end
            S_NEW: begin
                w_ctl.mul = (r_step == 4'd0) || (r_step == 4'd1);
                w_ma      = (r_step == 4'd0) ? MUL_W'(r_a) : MUL_W'(r_b);
                w_mb      = MUL_W'($signed({1'b0, r_s}));
            end
            S_SW_MUL: begin
                w_ctl = '{mul: 1'b1, acc: 1'b1, clr: r_first && (r_k == 2'd0)};
                w_ma  = MUL_W'($signed(r_cs[r_k]));
                w_mb  = MUL_W'(D_W'($signed(r_ls[r_k])) + D_W'($signed(r_bs[r_k])));
            end
            S_LC_MUL: begin
                w_ctl = '{mul: 1'b1, acc: 1'b1, clr: r_k == 2'd0};
                w_ma  = MUL_W'(r_nb[r_k]);
                w_mb  = MUL_W'(w_d[r_k]);
            end
            default: w_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_side      <= CFG_W'(MAX_SIDE);
            r_pending   <= 1'b0;
            r_measured  <= 1'b0;
            r_energy    <= '0;
            r_sv_energy <= '0;
            r_sv_spin   <= '0;
            r_sv_site   <= '0;
            r_ovalid    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_mag[k]    <= '0;
                r_sv_mag[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_side <= i_cfg_data;
            end
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in.op;
                        r_x     <= i_in.site_x;
                        r_y     <= i_in.site_y;
                        r_a     <= i_in.val_a;
                        r_b     <= i_in.val_b;
                        r_c     <= i_in.val_c;
                        r_n     <= w_side_use;
                        r_step  <= 4'(SIDE_BITS - 1);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    // restoring reduction of the site modulo the side
                    if (MOD_W'(r_x) >= w_nsh) begin
                        r_x <= SIDE_BITS'(MOD_W'(r_x) - w_nsh);
                    end
                    if (MOD_W'(r_y) >= w_nsh) begin
                        r_y <= SIDE_BITS'(MOD_W'(r_y) - w_nsh);
                    end
                    if (r_step == 4'd0) begin
                        r_state <= S_DISP;
                    end else begin
                        r_step <= r_step - 4'd1;
                    end
                end
                S_DISP: begin
                    r_status <= ST_DONE;
                    r_step   <= 4'd0;
                    r_state  <= S_FIN;
                    case (r_op)
                        OP_LOAD: r_measured <= 1'b0;
                        OP_PROPOSE: r_state <= S_SQ;
                        OP_ACCEPT: begin
                            r_sv_energy <= r_energy;
                            for (int k = 0; k < 3; k++) begin
                                r_sv_mag[k] <= r_mag[k];
                            end
                            r_pending <= 1'b0;
                        end
                        OP_REJECT: begin
                            if (!r_pending) begin
                                r_status <= ST_NOPEND;
                            end else begin
                                r_energy <= r_sv_energy;
                                for (int k = 0; k < 3; k++) begin
                                    r_mag[k] <= r_sv_mag[k];
                                end
                                r_pending <= 1'b0;
                            end
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_SQ: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd3) begin
                        if (w_acc > ONE_SQ) begin
                            r_status <= ST_REDRAW;
                            r_state  <= S_FIN;
                        end else begin
                            r_rr    <= RR_W'(w_acc);
                            r_d     <= RR_W'(ONE_SQ - w_acc);
                            r_s     <= '0;
                            r_bit   <= BIT_W'(FRAC_BITS);
                            r_k     <= 2'd0;
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_ROOT: begin
                    if (!r_k[0]) begin
                        r_k <= 2'd1;
                    end else begin
                        r_old <= w_rdata;
                        if (ACC_W'(w_prod) <= $signed(ACC_W'(r_d))) begin
                            r_s <= w_t;
                        end
                        r_k <= 2'd0;
                        if (r_bit == '0) begin
                            r_step  <= 4'd0;
                            r_state <= S_NEW;
                        end else begin
                            r_bit <= r_bit - BIT_W'(1);
                        end
                    end
                end
                S_NEW: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd1) begin
                        r_nx <= w_rnd;
                    end
                    if (r_step == 4'd2) begin
                        r_new     <= {w_nz, w_rnd, r_nx};
                        r_sv_spin <= r_old;
                        r_sv_site <= {r_x, r_y};
                        r_pending <= 1'b1;
                        r_step    <= 4'd0;
                        if (!r_measured) begin
                            r_measured <= 1'b1;
                            r_sx       <= '0;
                            r_sy       <= '0;
                            r_first    <= 1'b1;
                            for (int k = 0; k < 3; k++) begin
                                r_m[k] <= '0;
                            end
                            r_state <= S_SW_RD;
                        end else begin
                            r_state <= S_LC_RD;
                        end
                    end
                end
                S_SW_RD: begin
                    r_step <= r_step + 4'd1;
                    case (r_step[1:0])
                        2'd1: r_cs <= w_rdata;
                        2'd2: r_ls <= w_rdata;
                        2'd3: begin
                            r_bs    <= w_rdata;
                            r_k     <= 2'd0;
                            r_state <= S_SW_MUL;
                        end
                        default: r_step <= 4'd1;
                    endcase
                end
                S_SW_MUL: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd0) begin
                        r_first <= 1'b0;
                        for (int k = 0; k < 3; k++) begin
                            r_m[k] <= r_m[k] + MSUM_W'($signed(r_cs[k]));
                        end
                    end
                    if (r_k == 2'd2) begin
                        r_step <= 4'd0;
                        if (r_sy == w_last) begin
                            r_sy <= '0;
                            if (r_sx == w_last) begin
                                r_state <= S_SW_FIN;
                            end else begin
                                r_sx    <= r_sx + SIDE_BITS'(1);
                                r_state <= S_SW_RD;
                            end
                        end else begin
                            r_sy    <= r_sy + SIDE_BITS'(1);
                            r_state <= S_SW_RD;
                        end
                    end
                end
                S_SW_FIN: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd1) begin
                        r_energy <= sat_e(-round_q(w_acc));
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= sat_m(ACC_W'(r_m[k]));
                        end
                        r_status <= ST_DONE;
                        r_state  <= S_FIN;
                    end
                end
                S_LC_RD: begin
                    r_step <= r_step + 4'd1;
                    for (int k = 0; k < 3; k++) begin
                        if (r_step == 4'd1) begin
                            r_nb[k] <= NB_W'($signed(w_rdata[k]));
                        end else if (r_step != 4'd0) begin
                            r_nb[k] <= r_nb[k] + NB_W'($signed(w_rdata[k]));
                        end
                    end
                    if (r_step == 4'd4) begin
                        r_k     <= 2'd0;
                        r_state <= S_LC_MUL;
                    end
                end
                S_LC_MUL: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_step  <= 4'd0;
                        r_state <= S_LC_FIN;
                    end
                end
                S_LC_FIN: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd1) begin
                        r_energy <= sat_e(ACC_W'(r_energy) - round_q(w_acc));
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= sat_m(ACC_W'(r_mag[k]) + ACC_W'(w_d[k]));
                        end
                        r_status <= ST_DONE;
                        r_state  <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_ovalid || !i_out_stall) begin
                        r_out.energy <= r_energy;
                        r_out.mag_x  <= r_mag[0];
                        r_out.mag_y  <= r_mag[1];
                        r_out.mag_z  <= r_mag[2];
                        r_out.status <= r_status;
                        r_ovalid     <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: rtl/hsl_checker.sv
// Port-level checker for the Heisenberg lattice update block, bound to the top.
`default_nettype none
`include "assert_macros.svh"

module hsl_checker import hsl_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire t_out_item        o_out
);

    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid)
    `CHK_ASSERT(a_out_stable, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> $stable(o_out))
    `CHK_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    `CHK_ASSERT_ALWAYS(a_reset_clean, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall))

endmodule

bind heisenberg_lattice_spin_update hsl_checker u_hsl_checker (.*);

`default_nettype wire
